@@ rtl/morse_pkg.sv @@
// Shared types, character codes and the Morse code table for the decoder.
`timescale 1ns / 1ps

package morse_pkg;

    // Character codes seen on the input and produced on the output
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] GAP_CHAR   = 8'd32;
    localparam logic [7:0] ERROR_CHAR = 8'd0;

    // Longest code in the table
    localparam int CODE_MAX_LEN = 7;

    // Entries in the queue between classifier and executor
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic       hit;
        logic [7:0] ch;
    } lookup_t;

    // Key: symbol count and symbol bits, symbol i at bit i, dash = 1.
    function automatic lookup_t morse_lookup(input logic [2:0] len, input logic [6:0] bits);
        lookup_t res;
        res.hit = 1'b1;
        res.ch  = ERROR_CHAR;
        case ({len, bits})
            {3'd2, 7'd2}:  res.ch = "A";
            {3'd4, 7'd1}:  res.ch = "B";
            {3'd4, 7'd5}:  res.ch = "C";
            {3'd3, 7'd1}:  res.ch = "D";
            {3'd1, 7'd0}:  res.ch = "E";
            {3'd4, 7'd4}:  res.ch = "F";
            {3'd3, 7'd3}:  res.ch = "G";
            {3'd4, 7'd0}:  res.ch = "H";
            {3'd2, 7'd0}:  res.ch = "I";
            {3'd4, 7'd14}: res.ch = "J";
            {3'd3, 7'd5}:  res.ch = "K";
            {3'd4, 7'd2}:  res.ch = "L";
            {3'd2, 7'd3}:  res.ch = "M";
            {3'd2, 7'd1}:  res.ch = "N";
            {3'd3, 7'd7}:  res.ch = "O";
            {3'd4, 7'd6}:  res.ch = "P";
            {3'd4, 7'd11}: res.ch = "Q";
            {3'd3, 7'd2}:  res.ch = "R";
            {3'd3, 7'd0}:  res.ch = "S";
            {3'd1, 7'd1}:  res.ch = "T";
            {3'd3, 7'd4}:  res.ch = "U";
            {3'd4, 7'd8}:  res.ch = "V";
            {3'd3, 7'd6}:  res.ch = "W";
            {3'd4, 7'd9}:  res.ch = "X";
            {3'd4, 7'd13}: res.ch = "Y";
            {3'd4, 7'd3}:  res.ch = "Z";
            {3'd5, 7'd31}: res.ch = "0";
            {3'd5, 7'd30}: res.ch = "1";
            {3'd5, 7'd28}: res.ch = "2";
            {3'd5, 7'd24}: res.ch = "3";
            {3'd5, 7'd16}: res.ch = "4";
            {3'd5, 7'd0}:  res.ch = "5";
            {3'd5, 7'd1}:  res.ch = "6";
            {3'd5, 7'd3}:  res.ch = "7";
            {3'd5, 7'd7}:  res.ch = "8";
            {3'd5, 7'd15}: res.ch = "9";
            {3'd6, 7'd42}: res.ch = ".";
            {3'd6, 7'd51}: res.ch = ",";
            {3'd6, 7'd12}: res.ch = "?";
            {3'd6, 7'd30}: res.ch = 8'h27;
            {3'd6, 7'd53}: res.ch = "!";
            {3'd5, 7'd9}:  res.ch = "/";
            {3'd5, 7'd13}: res.ch = "(";
            {3'd6, 7'd45}: res.ch = ")";
            {3'd5, 7'd2}:  res.ch = "&";
            {3'd6, 7'd7}:  res.ch = ":";
            {3'd6, 7'd21}: res.ch = ";";
            {3'd5, 7'd17}: res.ch = "=";
            {3'd5, 7'd10}: res.ch = "+";
            {3'd6, 7'd33}: res.ch = "-";
            {3'd6, 7'd44}: res.ch = "_";
            {3'd6, 7'd18}: res.ch = 8'h22;
            {3'd7, 7'd72}: res.ch = "$";
            {3'd6, 7'd22}: res.ch = "@";
            default:
            begin
                res.hit = 1'b0;
                res.ch  = ERROR_CHAR;
            end
        endcase
        return res;
    endfunction

endpackage

@@ rtl/morse_front.sv @@
// Input side: classify characters, build the pending pattern, queue separators.
`timescale 1ns / 1ps

module morse_front #(
    parameter int MAX_SYMBOLS = 7,
    parameter int LEN_W       = $clog2(MAX_SYMBOLS + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_char,
    input  logic                   in_eom,
    input  logic                   in_flush,
    output logic                   sep_valid,
    input  logic                   sep_ready,
    output logic [MAX_SYMBOLS-1:0] sep_bits,
    output logic [LEN_W-1:0]       sep_len,
    output logic                   sep_invalid,
    output logic                   sep_two
);
    import morse_pkg::*;

    localparam int IDX_W = $clog2(MAX_SYMBOLS);

    logic [MAX_SYMBOLS-1:0] pattern_bits_reg, pattern_bits_next;
    logic [LEN_W-1:0]       pattern_len_reg, pattern_len_next;
    logic                   pattern_invalid_reg, pattern_invalid_next;

    logic                   is_space;
    logic                   is_symbol;
    logic                   accept;
    logic [MAX_SYMBOLS-1:0] after_bits;
    logic [LEN_W-1:0]       after_len;
    logic                   after_invalid;

    assign is_space  = (in_char == CHAR_SPACE) || ((in_char >= CHAR_TAB) && (in_char <= CHAR_CR));
    assign is_symbol = !in_flush && !is_space;
    assign in_ready  = sep_ready;
    assign accept    = in_valid && in_ready;

    // Pattern after this item's character, before any separator
    always_comb
    begin
        after_bits    = pattern_bits_reg;
        after_len     = pattern_len_reg;
        after_invalid = pattern_invalid_reg;
        if (is_symbol)
        begin
            if (pattern_len_reg >= LEN_W'(MAX_SYMBOLS))
            begin
                after_invalid = 1'b1;
            end
            else
            begin
                if (in_char == CHAR_DASH)
                begin
                    after_bits[pattern_len_reg[IDX_W-1:0]] = 1'b1;
                end
                else if (in_char != CHAR_DOT)
                begin
                    after_invalid = 1'b1;
                end
                after_len = pattern_len_reg + LEN_W'(1);
            end
        end
    end

    assign sep_valid   = in_valid && (in_eom || (!in_flush && is_space));
    assign sep_bits    = after_bits;
    assign sep_len     = after_len;
    assign sep_invalid = after_invalid;
    assign sep_two     = !in_flush && is_space && in_eom;

    always_comb
    begin
        pattern_bits_next    = pattern_bits_reg;
        pattern_len_next     = pattern_len_reg;
        pattern_invalid_next = pattern_invalid_reg;
        if (accept)
        begin
            if (sep_valid)
            begin
                pattern_bits_next    = '0;
                pattern_len_next     = '0;
                pattern_invalid_next = 1'b0;
            end
            else
            begin
                pattern_bits_next    = after_bits;
                pattern_len_next     = after_len;
                pattern_invalid_next = after_invalid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bits_reg    <= '0;
            pattern_len_reg     <= '0;
            pattern_invalid_reg <= 1'b0;
        end
        else
        begin
            pattern_bits_reg    <= pattern_bits_next;
            pattern_len_reg     <= pattern_len_next;
            pattern_invalid_reg <= pattern_invalid_next;
        end
    end

    // An invalid mark always comes with at least one pending symbol
    a_invalid_has_symbols: assert property (@(posedge clk) disable iff (!rst_n)
        pattern_invalid_reg |-> (pattern_len_reg != '0))
        else $error("invalid pattern with no pending symbols");

endmodule

@@ rtl/morse_queue.sv @@
// Short FIFO of separator entries between classifier and executor.
`timescale 1ns / 1ps

module morse_queue #(
    parameter int DATA_W = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              head_valid,
    input  logic              pop,
    output logic [DATA_W-1:0] head_data
);
    import morse_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

@@ rtl/morse_back.sv @@
// Output side: look up queued patterns and drive the result register.
`timescale 1ns / 1ps

module morse_back #(
    parameter int MAX_SYMBOLS = 7,
    parameter int LEN_W       = $clog2(MAX_SYMBOLS + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  logic [MAX_SYMBOLS-1:0] head_bits,
    input  logic [LEN_W-1:0]       head_len,
    input  logic                   head_invalid,
    input  logic                   head_two,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_char,
    output logic                   out_error,
    output logic                   out_last
);
    import morse_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg, out_char_next;
    logic       out_error_reg, out_error_next;
    logic       out_last_reg, out_last_next;
    logic       phase_reg, phase_next;

    lookup_t    hit;
    logic       fits;
    logic       load;
    logic [7:0] res_char;
    logic       res_error;
    logic       res_last;

    assign fits = (head_len <= LEN_W'(CODE_MAX_LEN));
    assign hit  = morse_lookup(head_len[2:0], head_bits[6:0]);
    assign load = head_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        res_char  = GAP_CHAR;
        res_error = 1'b0;
        res_last  = 1'b1;
        if (!phase_reg)
        begin
            res_last = !head_two;
            if (head_len == '0)
            begin
                res_char = GAP_CHAR;
            end
            else if (head_invalid || !fits || !hit.hit)
            begin
                res_char  = ERROR_CHAR;
                res_error = 1'b1;
            end
            else
            begin
                res_char = hit.ch;
            end
        end
    end

    // Second result of a pair is always the gap; hold the entry until then
    assign pop = load && (phase_reg || !head_two);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_error_next = out_error_reg;
        out_last_next  = out_last_reg;
        phase_next     = phase_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_char_next  = res_char;
            out_error_next = res_error;
            out_last_next  = res_last;
            phase_next     = !phase_reg && head_two;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg  <= out_char_next;
        out_error_reg <= out_error_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_error = out_error_reg;
    assign out_last  = out_last_reg;

    a_phase_holds_entry: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (head_valid && head_two))
        else $error("second result pending without its entry");

    a_pair_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |=> out_valid_reg)
        else $error("first of a result pair not followed by the second");

endmodule

@@ rtl/morse_decoder.sv @@
// Top level of the Morse text decoder: classifier, queue and lookup stage.
//
// Usage
//   Input channel s_axis: one item per text character. tdata is the ASCII
//   character, tlast marks the end of a message (a final separator follows
//   the character), tuser set means the item carries no character, only the
//   end marker. Dots and dashes build a pending pattern; whitespace or the
//   end of a message decodes it.
//   Output channel m_axis: tdata is the decoded character (space for a gap,
//   zero for an unknown or malformed pattern), tuser flags that error, and
//   tlast marks the last result caused by one input item.
//   A result goes from the accepted item into the queue, then through the
//   table lookup into the output register. Throughput: one item per cycle
//   while the queue has room. An item with two results (whitespace at the
//   end of a message) keeps its queue entry until the second result, the
//   gap, is loaded; items that give no result pass straight through the
//   classifier.
//   Reset clears the pending pattern, the queue and the output valid and last.
//   When the receiver stalls, the result waits in the output register, the
//   two-entry queue keeps taking items until full, then s_axis_tready drops.
`timescale 1ns / 1ps

module morse_decoder #(
    parameter int MAX_SYMBOLS = 7
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] symbol_char
    input  logic       s_axis_tlast,   // end_of_message
    input  logic       s_axis_tuser,   // [0] flush_only
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] decoded_char
    output logic       m_axis_tlast,   // last_of_run
    output logic       m_axis_tuser    // [0] pattern_error
);
    import morse_pkg::*;

    localparam int LEN_W   = $clog2(MAX_SYMBOLS + 1);
    localparam int ENTRY_W = MAX_SYMBOLS + LEN_W + 2;

    // Separator entry from the classifier
    logic                   sep_valid;
    logic                   sep_ready;
    logic [MAX_SYMBOLS-1:0] sep_bits;
    logic [LEN_W-1:0]       sep_len;
    logic                   sep_invalid;
    logic                   sep_two;

    // Queue head toward the lookup stage
    logic                   head_valid;
    logic                   head_pop;
    logic [ENTRY_W-1:0]     head_data;
    logic [ENTRY_W-1:0]     push_data;

    // Classify characters and keep the pending pattern
    morse_front #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .LEN_W       (LEN_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_char     (s_axis_tdata),
        .in_eom      (s_axis_tlast),
        .in_flush    (s_axis_tuser),
        .sep_valid   (sep_valid),
        .sep_ready   (sep_ready),
        .sep_bits    (sep_bits),
        .sep_len     (sep_len),
        .sep_invalid (sep_invalid),
        .sep_two     (sep_two)
    );

    // Pack entry: two-result flag on top, pattern bits at the bottom
    assign push_data = {sep_two, sep_invalid, sep_len, sep_bits};

    morse_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (sep_valid),
        .push_ready (sep_ready),
        .push_data  (push_data),
        .head_valid (head_valid),
        .pop        (head_pop),
        .head_data  (head_data)
    );

    // Look up the pattern and drive the output register
    morse_back #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .LEN_W       (LEN_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_bits    (head_data[MAX_SYMBOLS-1:0]),
        .head_len     (head_data[MAX_SYMBOLS+LEN_W-1:MAX_SYMBOLS]),
        .head_invalid (head_data[ENTRY_W-2]),
        .head_two     (head_data[ENTRY_W-1]),
        .pop          (head_pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_char     (m_axis_tdata),
        .out_error    (m_axis_tuser),
        .out_last     (m_axis_tlast)
    );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for morse_decoder: directed and random Morse text against a predictor.
`timescale 1ns / 1ps

module testbench;

    import morse_pkg::*;

    // Run length guard, far above the slowest legal run
    localparam int CYCLE_LIMIT = 200000;
    // Cycles to let the pipeline settle once nothing is pending
    localparam int TAIL_CYCLES = 8;

    typedef struct {
        logic [7:0] ch;
        logic       err;
        logic       last;
    } decoded_t;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;    // [7:0] symbol_char
    logic       s_axis_tlast;    // end_of_message
    logic       s_axis_tuser;    // [0] flush_only
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;    // [7:0] decoded_char
    logic       m_axis_tlast;    // last_of_run
    logic       m_axis_tuser;    // [0] pattern_error

    // Standard Morse codes and the characters they stand for, in matching order
    string codes [54] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..",
        "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
        "---..", "----.",
        ".-.-.-", "--..--", "..--..", ".----.", "-.-.--", "-..-.", "-.--.",
        "-.--.-", ".-...", "---...", "-.-.-.", "-...-", ".-.-.", "-....-",
        "..--.-", ".-..-.", "...-..-", ".--.-."
    };
    logic [7:0] glyphs [54] = '{
        "A", "B", "C", "D", "E", "F", "G", "H", "I", "J",
        "K", "L", "M", "N", "O", "P", "Q", "R", "S", "T",
        "U", "V", "W", "X", "Y", "Z",
        "0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
        ".", ",", "?", 8'h27, "!", "/", "(",
        ")", "&", ":", ";", "=", "+", "-",
        "_", 8'h22, "$", "@"
    };

    // Predictor state: the pattern still waiting for a separator
    logic [6:0] pat_bits = '0;
    logic [2:0] pat_len  = '0;
    logic       pat_bad  = 1'b0;

    decoded_t decoded_q [$];

    int errors         = 0;
    int items_sent     = 0;
    int cycles         = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    morse_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic bit is_blank(input logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    // Search the code list for the pending pattern.
    function automatic bit find_code(output logic [7:0] ch);
        int         e;
        int         k;
        logic [6:0] b;
        ch = ERROR_CHAR;
        for (e = 0; e < 54; e++)
        begin
            if (codes[e].len() == int'(pat_len))
            begin
                b = '0;
                for (k = 0; k < codes[e].len(); k++)
                    if (codes[e][k] == CHAR_DASH)
                        b[k] = 1'b1;
                if (b == pat_bits)
                begin
                    ch = glyphs[e];
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Grow the pending pattern; the length saturates at the longest code.
    function automatic void absorb_symbol(input logic [7:0] c);
        if (pat_len == 3'(CODE_MAX_LEN))
        begin
            pat_bad = 1'b1;
            return;
        end
        if (c == CHAR_DASH)
            pat_bits[pat_len] = 1'b1;
        else if (c != CHAR_DOT)
            pat_bad = 1'b1;
        pat_len = pat_len + 3'd1;
    endfunction

    // Separator: decode the pending pattern, or emit a gap when none waits.
    function automatic void close_pattern();
        decoded_t r;
        logic [7:0] ch;
        r.err  = 1'b0;
        r.last = 1'b0;
        if (pat_len == 3'd0)
            r.ch = GAP_CHAR;
        else if (pat_bad || !find_code(ch))
        begin
            r.ch  = ERROR_CHAR;
            r.err = 1'b1;
        end
        else
            r.ch = ch;
        decoded_q.push_back(r);
        pat_bits = '0;
        pat_len  = '0;
        pat_bad  = 1'b0;
    endfunction

    function automatic void decode_item(input logic [7:0] c, input logic eom,
                                        input logic flush);
        int       n0;
        decoded_t r;
        n0 = decoded_q.size();
        if (!flush)
        begin
            if (is_blank(c))
                close_pattern();
            else
                absorb_symbol(c);
        end
        if (eom)
            close_pattern();
        // Mark the final result of this item
        if (decoded_q.size() > n0)
        begin
            r = decoded_q.pop_back();
            r.last = 1'b1;
            decoded_q.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    // Offer one item at a falling edge, idling first at random, and hold it
    // until a rising edge takes it.
    task automatic send_item(input logic [7:0] c, input logic eom, input logic flush);
        bit idle;
        idle = 1'b1;
        while (idle)
        begin
            @(negedge clk);
            idle = ($urandom_range(0, 99) < src_idle_pct);
            if (idle)
                s_axis_tvalid <= 1'b0;
            else
            begin
                s_axis_tdata  <= c;
                s_axis_tlast  <= eom;
                s_axis_tuser  <= flush;
                s_axis_tvalid <= 1'b1;
            end
        end
        do
            @(posedge clk);
        while (!s_axis_tready);
        decode_item(c, eom, flush);
        // A flush without an end marker is ignored by the block
        if (!(flush && !eom))
            items_sent++;
    endtask

    // Send a run of text, marking the end of message on its last character.
    task automatic send_text(input string s, input logic eom_on_last);
        int k;
        for (k = 0; k < s.len(); k++)
            send_item(s[k], eom_on_last && k == s.len() - 1, 1'b0);
    endtask

    function automatic logic [7:0] any_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r < 5) ? CHAR_TAB + 8'(r) : CHAR_SPACE;
    endfunction

    // Drop valid, then wait for every predicted result plus a short tail.
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("MISMATCH %s: got %02h expected %02h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Receiver: stall at the rate of the current phase
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

    // Compare each taken result with the oldest prediction
    always @(posedge clk)
    begin
        decoded_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (decoded_q.size() == 0)
                report_mismatch("result with nothing pending", m_axis_tdata, 8'h00);
            else
            begin
                want = decoded_q.pop_front();
                if (m_axis_tdata != want.ch)
                    report_mismatch("decoded_char", m_axis_tdata, want.ch);
                if (m_axis_tuser != want.err)
                    report_mismatch("pattern_error", 8'(m_axis_tuser), 8'(want.err));
                if (m_axis_tlast != want.last)
                    report_mismatch("last_of_run", 8'(m_axis_tlast), 8'(want.last));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("morse_decoder regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Four symbols with no table entry, closed by a space
    task automatic test_unknown_pattern();
        send_text("..-- ", 1'b0);
        wait_drained();
    endtask

    // Seven-symbol code, decoded by the end marker on its last symbol
    task automatic test_longest_code();
        send_text("...-..-", 1'b1);
        wait_drained();
    endtask

    // Eight dashes: the last one overflows, a bare end marker closes it
    task automatic test_overlong_pattern();
        send_text("--------", 1'b0);
        send_item(8'h2E, 1'b1, 1'b1);
        wait_drained();
    endtask

    // Flush without end must give nothing, even carrying whitespace;
    // flush with end on an empty pattern gives a gap
    task automatic test_flush_marker();
        send_item(CHAR_SPACE, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(CHAR_DOT, 1'b1, 1'b1);
        wait_drained();
    endtask

    // Whitespace ending a message: the letter, then a gap
    task automatic test_double_separator();
        send_item(CHAR_DOT, 1'b0, 1'b0);
        send_item(CHAR_CR, 1'b1, 1'b0);
        wait_drained();
    endtask

    // Codes other than dot and dash spoil the pattern
    task automatic test_foreign_symbols();
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'd10, 1'b1, 1'b0);
        wait_drained();
    endtask

    // Mostly well-formed words with random separators, plus noise,
    // long patterns and stray markers
    task automatic test_random_traffic(input int n, input int src_pct, input int sink_pct);
        int    start;
        int    roll;
        int    e;
        int    k;
        int    len;
        int    mode;
        string code;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        start = items_sent;
        while (items_sent - start < n)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 65)
            begin
                e    = $urandom_range(0, 53);
                code = codes[e];
                mode = $urandom_range(0, 9);
                for (k = 0; k < code.len(); k++)
                    send_item(code[k], mode == 0 && k == code.len() - 1, 1'b0);
                if (mode == 1)
                    send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
                else if (mode != 0)
                    send_item(any_blank(), mode == 2, 1'b0);
            end
            else if (roll < 77)
            begin
                len = $urandom_range(5, 9);
                for (k = 0; k < len; k++)
                    send_item($urandom_range(0, 1) ? CHAR_DASH : CHAR_DOT, 1'b0, 1'b0);
                send_item(any_blank(), $urandom_range(0, 3) == 0, 1'b0);
            end
            else if (roll < 90)
                send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                          $urandom_range(0, 7) == 0);
            else if (roll < 95)
                send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            else
                send_item(any_blank(), 1'($urandom_range(0, 1)), 1'b0);
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b1;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_unknown_pattern();
        test_longest_code();
        test_overlong_pattern();
        test_flush_marker();
        test_double_separator();
        test_foreign_symbols();

        test_random_traffic(330, 0, 0);
        test_random_traffic(320, 82, 0);
        test_random_traffic(320, 0, 82);
        test_random_traffic(330, 12, 12);

        if (errors == 0)
            $display("morse_decoder regression: pass");
        else
            $display("morse_decoder regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/morse_pkg.sv
rtl/morse_front.sv
rtl/morse_queue.sv
rtl/morse_back.sv
rtl/morse_decoder.sv
tb/testbench.sv
